// ----- src/drt_pkg.sv -----
package drt_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int VW   = 13;             // millivolt width
   localparam int FW   = 20;             // fixed resistor width
   localparam int RW   = 32;             // resistance width
   localparam int AGW  = 16;             // angle width
   localparam int NUMW = FW + VW;        // divider numerator width
   localparam int DQW  = 50;             // shared divider dividend/quotient width
   localparam int CNTW = 6;
   localparam int DIV1_STEPS = NUMW;
   localparam int DIV2_STEPS = DQW;
   localparam int CSR_IW = 4;
   localparam int CSR_DW = 32;

   typedef enum logic [CSR_IW-1:0] {
      CSR_VREF       = 4'd0,
      CSR_FIXED      = 4'd1,
      CSR_HIGH_SIDE  = 4'd2,
      CSR_TABLE_SIZE = 4'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_LOAD,
      KIND_RAIL,
      KIND_CONVERT
   } kind_type;

   typedef struct packed {
      kind_type               kind;
      logic [NUMW-1:0]        num;
      logic [VW-1:0]          den;
      logic [3:0]             index;
      logic [RW-1:0]          pres;
      logic signed [AGW-1:0]  pang;
   } cmd_type;

   typedef struct packed {
      logic [VW-1:0] vref_mv;
      logic [FW-1:0] fixed_ohms;
      logic          high_side;
   } conv_cfg_type;

   typedef struct packed {
      logic [RW-1:0]         res;
      logic signed [AGW-1:0] ang;
   } point_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_WALK_RD,
      ST_WALK_CHK,
      ST_MUL,
      ST_SUM,
      ST_DONE
   } state_type;

endpackage

// ----- src/drt_front.sv -----
module drt_front
   import drt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  conv_cfg_type          cfg,
   input  logic                  push,
   output logic                  full,
   input  logic                  mode,
   input  logic [VW-1:0]         voltage_mv,
   input  logic [3:0]            entry_index,
   input  logic [RW-1:0]         entry_resistance,
   input  logic signed [AGW-1:0] entry_angle,
   output logic                  cmd_valid,
   output cmd_type               cmd,
   input  logic                  cmd_pop
);

   cmd_type       ent_ff [2];
   logic          wr_ptr_ff, wr_ptr_in;
   logic          rd_ptr_ff, rd_ptr_in;
   logic [1:0]    count_ff, count_in;
   cmd_type       cmd_new;
   logic [VW-1:0] diff;
   logic [VW-1:0] mul_v;
   logic          rail;
   logic          do_push;

   // classify and precompute the divider operands
   always_comb begin
      diff  = cfg.vref_mv - voltage_mv;
      rail  = (voltage_mv <= VW'(1)) ||
              ({1'b0, voltage_mv} + 14'd1 >= {1'b0, cfg.vref_mv});
      mul_v = cfg.high_side ? voltage_mv : diff;
      cmd_new.num   = NUMW'(cfg.fixed_ohms) * NUMW'(mul_v);
      cmd_new.den   = cfg.high_side ? diff : voltage_mv;
      cmd_new.index = entry_index;
      cmd_new.pres  = entry_resistance;
      cmd_new.pang  = entry_angle;
      if (mode) begin
         cmd_new.kind = KIND_LOAD;
      end else if (rail) begin
         cmd_new.kind = KIND_RAIL;
      end else begin
         cmd_new.kind = KIND_CONVERT;
      end
   end

   assign full      = (count_ff == 2'd2);
   assign do_push   = push && !full;
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = ent_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         ent_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule

// ----- src/drt_back.sv -----
module drt_back
   import drt_pkg::*;
#(
   parameter int TABLE_DEPTH = DEPTH_DEFAULT
)(
   input  logic                  clock,
   input  logic                  reset,
   input  logic [4:0]            table_size,
   input  logic                  cmd_valid,
   input  cmd_type               cmd,
   output logic                  cmd_pop,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic [RW-1:0]         rsp_resistance_ohms,
   output logic                  rsp_reading_valid,
   output logic signed [AGW-1:0] rsp_angle_centideg
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   point_type             mem [TABLE_DEPTH];
   point_type             rd_ff;

   state_type             state_ff, state_in;
   logic [DQW-1:0]        dq_ff;
   logic [RW-1:0]         rem_ff;
   logic [RW-1:0]         dvs_ff;
   logic [CNTW-1:0]       cnt_ff;
   logic                  phase_ff;
   logic                  neg_ff;
   logic [RW-1:0]         r_ff;
   logic                  rdv_ff;
   logic signed [AGW-1:0] ang_ff;
   logic [CW-1:0]         idx_ff;
   logic [RW-1:0]         r0_ff, r1_ff;
   logic signed [AGW-1:0] a0_ff, a1_ff;
   logic signed [48:0]    p1_ff;
   logic signed [49:0]    p2_ff;

   logic                  out_valid_ff;
   logic [RW-1:0]         out_res_ff;
   logic                  out_rdv_ff;
   logic signed [AGW-1:0] out_ang_ff;

   logic [CW-1:0]         n_pts;
   logic                  slot_free;
   logic                  mem_we;
   logic                  out_load;
   logic [RW:0]           trial;
   logic                  q_bit;
   logic [RW-1:0]         rem_next;
   logic [RW-1:0]         span;
   logic [RW-1:0]         r_offset;
   logic signed [16:0]    dang;
   logic signed [50:0]    numer;
   logic [50:0]           mag;
   logic [AGW-1:0]        q16;
   logic                  hit;

   assign n_pts     = (32'(table_size) > TABLE_DEPTH) ? CW'(TABLE_DEPTH) : CW'(table_size);
   assign slot_free = !out_valid_ff || rsp_pop;
   assign hit       = (r_ff <= rd_ff.res);

   // one restoring step of the shared divider
   always_comb begin
      trial    = {rem_ff, dq_ff[DQW-1]};
      q_bit    = (trial >= {1'b0, dvs_ff});
      rem_next = q_bit ? RW'(trial - {1'b0, dvs_ff}) : trial[RW-1:0];
   end

   always_comb begin
      span     = r1_ff - r0_ff;
      r_offset = r_ff - r0_ff;
      dang     = {a1_ff[AGW-1], a1_ff} - {a0_ff[AGW-1], a0_ff};
      numer    = {{2{p1_ff[48]}}, p1_ff} + {p2_ff[49], p2_ff};
      mag      = numer[50] ? 51'(-numer) : 51'(numer);
      q16      = dq_ff[AGW-1:0];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               case (cmd.kind)
                  KIND_RAIL:    state_in = ST_DONE;
                  KIND_CONVERT: state_in = ST_DIV;
                  default:      state_in = ST_IDLE;
               endcase
            end
         end
         ST_DIV: begin
            if (cnt_ff == '0) begin
               if (phase_ff || n_pts == '0) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_WALK_RD;
               end
            end
         end
         ST_WALK_RD:  state_in = ST_WALK_CHK;
         ST_WALK_CHK: begin
            if (hit) begin
               if (idx_ff == '0 || rd_ff.res <= r0_ff) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_MUL;
               end
            end else if (idx_ff + CW'(1) == n_pts) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_WALK_RD;
            end
         end
         ST_MUL:  state_in = ST_SUM;
         ST_SUM:  state_in = ST_DIV;
         ST_DONE: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control strobes
   always_comb begin
      cmd_pop  = (state_ff == ST_IDLE) && cmd_valid;
      mem_we   = cmd_pop && (cmd.kind == KIND_LOAD) && (32'(cmd.index) < TABLE_DEPTH);
      out_load = (state_ff == ST_DONE) && slot_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // calibration store
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[AW'(cmd.index)] <= '{res: cmd.pres, ang: cmd.pang};
      end
      rd_ff <= mem[idx_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            r_ff   <= '0;
            rdv_ff <= 1'b0;
            ang_ff <= '0;
            dq_ff  <= {cmd.num, (DQW - NUMW)'(0)};
            rem_ff <= '0;
            dvs_ff <= RW'(cmd.den);
            cnt_ff <= CNTW'(DIV1_STEPS);
            phase_ff <= 1'b0;
            idx_ff <= '0;
         end
         ST_DIV: begin
            if (cnt_ff != '0) begin
               dq_ff  <= {dq_ff[DQW-2:0], q_bit};
               rem_ff <= rem_next;
               cnt_ff <= cnt_ff - CNTW'(1);
            end else if (!phase_ff) begin
               r_ff   <= dq_ff[NUMW-1] ? '1 : dq_ff[RW-1:0];
               rdv_ff <= 1'b1;
            end else begin
               ang_ff <= neg_ff ? AGW'(-q16) : q16;
            end
         end
         ST_WALK_CHK: begin
            if (hit) begin
               ang_ff <= rd_ff.ang;
               r1_ff  <= rd_ff.res;
               a1_ff  <= rd_ff.ang;
            end else begin
               ang_ff <= rd_ff.ang;
               r0_ff  <= rd_ff.res;
               a0_ff  <= rd_ff.ang;
               idx_ff <= idx_ff + CW'(1);
            end
         end
         ST_MUL: begin
            p1_ff <= a0_ff * $signed({1'b0, span});
            p2_ff <= $signed({1'b0, r_offset}) * dang;
         end
         ST_SUM: begin
            neg_ff   <= numer[50];
            dq_ff    <= mag[DQW-1:0];
            rem_ff   <= '0;
            dvs_ff   <= span;
            cnt_ff   <= CNTW'(DIV2_STEPS);
            phase_ff <= 1'b1;
         end
         default: begin
         end
      endcase
      if (out_load) begin
         out_res_ff <= r_ff;
         out_rdv_ff <= rdv_ff;
         out_ang_ff <= ang_ff;
      end
   end

   assign rsp_empty           = !out_valid_ff;
   assign rsp_resistance_ohms = out_res_ff;
   assign rsp_reading_valid   = out_rdv_ff;
   assign rsp_angle_centideg  = out_ang_ff;

   a_div_runs: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && cnt_ff != '0) |=> state_ff == ST_DIV)
      else $error("divider left before its last step");

   a_read_aligned: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK_CHK) |-> $past(state_ff) == ST_WALK_RD)
      else $error("table compare without a fresh read");

   a_interp_bracket: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL) |-> (r_ff > r0_ff && r_ff <= r1_ff))
      else $error("interpolation outside its bracket");

endmodule

// ----- src/divider_resistance_to_angle.sv -----
// Flex-sensor divider voltage to resistance and joint angle.
//
// Request channel (req_*): queue style, push/full. mode 0 converts
// req_voltage_mv, mode 1 stores one calibration point at req_entry_index.
// Response channel (rsp_*): queue style, empty/pop; one response per
// conversion, none for a point load.
// CSR channel (csr_*): valid/ready write of vref, fixed resistor, divider
// side and table size. Write only while no transaction is in flight.
//
// A point load leaves the queue and is written to the store; a sample at
// a rail leaves the queue and goes to the output register. A conversion
// leaves the queue, runs the shared restoring divider for the resistance,
// walks the table (one registered memory read and one compare per point
// visited, at most TABLE_DEPTH points) and, when it interpolates,
// multiplies, sums and runs a 50-step quotient before loading the output.
// One transaction is worked at a time; a two-entry request queue keeps
// accepting meanwhile until it is full.
// Reset clears the queue, the engine and the CSRs to their defaults; the
// calibration store is not cleared. When the receiver stalls, the finished
// response holds in the output register and the engine waits for it.
module divider_resistance_to_angle
   import drt_pkg::*;
#(
   parameter int TABLE_DEPTH = DEPTH_DEFAULT
)(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  logic                  req_mode,
   input  logic [VW-1:0]         req_voltage_mv,
   input  logic [3:0]            req_entry_index,
   input  logic [RW-1:0]         req_entry_resistance,
   input  logic signed [AGW-1:0] req_entry_angle,
   output logic                  empty,
   input  logic                  pop,
   output logic [RW-1:0]         rsp_resistance_ohms,
   output logic                  rsp_reading_valid,
   output logic signed [AGW-1:0] rsp_angle_centideg,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IW-1:0]     csr_index,
   input  logic [CSR_DW-1:0]     csr_wdata
);

   // configuration registers
   logic [VW-1:0] vref_ff;
   logic [FW-1:0] fixed_ff;
   logic          high_ff;
   logic [4:0]    tsize_ff;

   conv_cfg_type  cfg;
   logic          cmd_valid;
   cmd_type       cmd;
   logic          cmd_pop;

   assign csr_ready = 1'b1;

   // decode and store CSR writes; unknown indexes drop
   always_ff @(posedge clock) begin
      if (reset) begin
         vref_ff  <= VW'(3300);
         fixed_ff <= FW'(47000);
         high_ff  <= 1'b0;
         tsize_ff <= 5'd0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_VREF:       vref_ff  <= csr_wdata[VW-1:0];
            CSR_FIXED:      fixed_ff <= csr_wdata[FW-1:0];
            CSR_HIGH_SIDE:  high_ff  <= csr_wdata[0];
            CSR_TABLE_SIZE: tsize_ff <= csr_wdata[4:0];
            default: begin
            end
         endcase
      end
   end

   assign cfg = '{vref_mv: vref_ff, fixed_ohms: fixed_ff, high_side: high_ff};

   // front: accept, classify, queue
   drt_front u_front (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .push             (push),
      .full             (full),
      .mode             (req_mode),
      .voltage_mv       (req_voltage_mv),
      .entry_index      (req_entry_index),
      .entry_resistance (req_entry_resistance),
      .entry_angle      (req_entry_angle),
      .cmd_valid        (cmd_valid),
      .cmd              (cmd),
      .cmd_pop          (cmd_pop)
   );

   // back: divide, walk the table, interpolate, hold the response
   drt_back #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .table_size          (tsize_ff),
      .cmd_valid           (cmd_valid),
      .cmd                 (cmd),
      .cmd_pop             (cmd_pop),
      .rsp_empty           (empty),
      .rsp_pop             (pop),
      .rsp_resistance_ohms (rsp_resistance_ohms),
      .rsp_reading_valid   (rsp_reading_valid),
      .rsp_angle_centideg  (rsp_angle_centideg)
   );

endmodule

// ----- tb/tb_divider_resistance_to_angle.sv -----
// Self-checking bench for the flex-sensor divider to resistance/angle block.
// A directed table runs first, then random phases; every phase rewrites all
// CSRs while the block is idle, optionally reloads the calibration table with
// an ascending point set, then mixes conversions with stray point loads.
module tb_divider_resistance_to_angle;
   import drt_pkg::*;

   localparam int NPOINTS     = 16;
   localparam int SETTLE      = 150;       // cycles to let a point load drain
   localparam int CYCLE_LIMIT = 1000000;
   localparam int NPHASES     = 11;
   localparam int PHASE_ITEMS = 40;
   localparam int NDIRECTED   = 22;

   typedef struct {
      logic [RW-1:0]         res;
      logic                  valid;
      logic signed [AGW-1:0] ang;
   } reading_type;

   typedef struct {
      logic                  mode;
      int unsigned           volt;
      int unsigned           idx;
      longint unsigned       res;
      int                    ang;
      bit                    typed;
      longint unsigned       e_res;
      bit                    e_valid;
      int                    e_ang;
   } row_type;

   logic                  clock;
   logic                  reset;
   logic                  push;
   logic                  full;
   logic                  req_mode;
   logic [VW-1:0]         req_voltage_mv;
   logic [3:0]            req_entry_index;
   logic [RW-1:0]         req_entry_resistance;
   logic signed [AGW-1:0] req_entry_angle;
   logic                  empty;
   logic                  pop;
   logic [RW-1:0]         rsp_resistance_ohms;
   logic                  rsp_reading_valid;
   logic signed [AGW-1:0] rsp_angle_centideg;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IW-1:0]     csr_index;
   logic [CSR_DW-1:0]     csr_wdata;

   divider_resistance_to_angle dut (.*);

   // shadow of the block's settings and calibration store
   int unsigned      sh_vref;
   int unsigned      sh_fixed;
   bit               sh_high;
   int unsigned      sh_size;
   longint unsigned  sh_pres [NPOINTS];
   int               sh_pang [NPOINTS];

   reading_type pending_readings[$];
   int          mismatches;
   int          n_conv, n_load, n_rail, n_phase;
   int          cycles;
   bit          no_idle;       // stretches with no gaps on either side
   int          pop_hold;
   row_type     dir_rows [NDIRECTED];

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // divider formula, saturated at 32 bits
   function automatic longint unsigned divider_ohms(int unsigned v);
      longint unsigned q;
      if (sh_high)
         q = (longint'(sh_fixed) * v) / (sh_vref - v);
      else
         q = (longint'(sh_fixed) * (sh_vref - v)) / v;
      return (q > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : q;
   endfunction

   function automatic int table_angle(longint unsigned r);
      int unsigned n;
      longint      rl, span, al, ar;
      n = (sh_size > NPOINTS) ? NPOINTS : sh_size;
      if (n == 0) return 0;
      if (r <= sh_pres[0]) return sh_pang[0];
      for (int i = 1; i < n; i++) begin
         if (r <= sh_pres[i]) begin
            rl   = longint'(sh_pres[i-1]);
            span = longint'(sh_pres[i]) - rl;
            al   = sh_pang[i-1];
            ar   = sh_pang[i];
            if (span <= 0) return int'(ar);
            // signed division truncates toward zero
            return int'((al * span + (longint'(r) - rl) * (ar - al)) / span);
         end
      end
      return sh_pang[n-1];
   endfunction

   function automatic reading_type predict_reading(int unsigned v);
      reading_type     rd;
      longint unsigned r;
      if (v <= 1 || v + 1 >= sh_vref) begin
         rd.res = '0; rd.valid = 1'b0; rd.ang = '0;
         return rd;
      end
      r        = divider_ohms(v);
      rd.res   = r[RW-1:0];
      rd.valid = 1'b1;
      rd.ang   = AGW'(table_angle(r));
      return rd;
   endfunction

   function automatic int pick_gap();
      int p;
      if (no_idle) return 0;
      p = $urandom_range(0, 99);
      if (p < 60) return 0;
      if (p < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // response side: check each popped transaction, stall at random
   always @(posedge clock) begin
      reading_type want;
      if (reset) begin
         pop      <= 1'b0;
         pop_hold <= 0;
      end else begin
         if (pop && !empty) begin
            if (pending_readings.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected response: res=%0d valid=%0b ang=%0d",
                           rsp_resistance_ohms, rsp_reading_valid, rsp_angle_centideg);
            end else begin
               want = pending_readings.pop_front();
               if (rsp_resistance_ohms !== want.res || rsp_reading_valid !== want.valid ||
                   rsp_angle_centideg !== want.ang) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: res exp %0d got %0d, valid exp %0b got %0b, ang exp %0d got %0d",
                              want.res, rsp_resistance_ohms, want.valid, rsp_reading_valid,
                              want.ang, rsp_angle_centideg);
               end
            end
         end
         // hold off now and then, mostly briefly, rarely for long
         if (pop_hold > 0) begin
            pop      <= 1'b0;
            pop_hold <= pop_hold - 1;
         end else begin
            pop <= 1'b1;
            if (!no_idle) begin
               if ($urandom_range(0, 19) == 0)
                  pop_hold <= $urandom_range(20, 60);
               else if ($urandom_range(0, 3) == 0)
                  pop_hold <= $urandom_range(1, 3);
            end
         end
      end
   end

   // Drive one write and wait until it is taken; the caller drops valid
   // after the last write of a burst.
   task automatic csr_write(csr_index_type idx, int unsigned data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_VREF:       sh_vref  = data & 32'h1FFF;
         CSR_FIXED:      sh_fixed = data & 32'hFFFFF;
         CSR_HIGH_SIDE:  sh_high  = data[0];
         CSR_TABLE_SIZE: sh_size  = data & 32'h1F;
         default: ;
      endcase
   endtask

   // Drive one transaction and wait until it is taken. Push stays high when
   // the next one follows back to back.
   task automatic send_item(logic mode, int unsigned volt, int unsigned idx,
                            longint unsigned res, int ang,
                            bit typed, reading_type typed_rd);
      int gap;
      push                 <= 1'b1;
      req_mode             <= mode;
      req_voltage_mv       <= VW'(volt);
      req_entry_index      <= 4'(idx);
      req_entry_resistance <= RW'(res);
      req_entry_angle      <= AGW'(ang);
      do @(posedge clock); while (full);
      if (mode) begin
         sh_pres[idx] = res & 64'hFFFF_FFFF;
         sh_pang[idx] = int'($signed(AGW'(ang)));
         n_load++;
      end else begin
         n_conv++;
         if (volt <= 1 || volt + 1 >= sh_vref) n_rail++;
         pending_readings.push_back(typed ? typed_rd : predict_reading(volt));
      end
      gap = pick_gap();
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_to_idle();
      push <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   function automatic int rand_angle();
      return int'($urandom_range(0, 36000)) - 18000;
   endfunction

   // ascending point set spread over the resistances this setting can give
   task automatic reload_table();
      longint unsigned pts [NPOINTS];
      longint unsigned lo, hi;
      reading_type     none;
      none = '{default: '0};
      if (sh_vref >= 5) begin
         lo = divider_ohms(sh_high ? 2 : sh_vref - 2) / 2;
         hi = divider_ohms(sh_high ? sh_vref - 2 : 2);
      end else begin
         lo = 0;
         hi = 64'hFFFF_FFFF;
      end
      if (hi <= lo) hi = lo + 16;
      foreach (pts[i])
         pts[i] = lo + ({$urandom, $urandom} % (hi - lo + 1));
      pts.sort();
      foreach (pts[i])
         send_item(1'b1, $urandom_range(0, 8191), i, pts[i], rand_angle(), 1'b0, none);
   endtask

   function automatic int unsigned rand_voltage();
      int p;
      p = $urandom_range(0, 99);
      if (p < 10 || sh_vref < 4) return $urandom_range(0, 8191);
      if (p < 15) return (p & 1) ? $urandom_range(0, 1) : sh_vref - 1;
      return $urandom_range(2, sh_vref - 2);
   endfunction

   initial begin
      reading_type typed_rd;
      int unsigned vref, fixed, size;
      bit          high;

      reset                = 1'b1;
      push                 = 1'b0;
      req_mode             = 1'b0;
      req_voltage_mv       = '0;
      req_entry_index      = '0;
      req_entry_resistance = '0;
      req_entry_angle      = '0;
      csr_valid            = 1'b0;
      csr_index            = CSR_VREF;
      csr_wdata            = '0;
      cycles = 0; mismatches = 0; no_idle = 0;
      n_conv = 0; n_load = 0; n_rail = 0; n_phase = 0;
      sh_vref = 3300; sh_fixed = 47000; sh_high = 0; sh_size = 0;
      foreach (sh_pres[i]) begin
         sh_pres[i] = 0;
         sh_pang[i] = 0;
      end

      // rails, empty-table conversions, then the full table: zero span at
      // points 1/2, descending angles, resistance extremes at both ends
      dir_rows = '{
         '{0, 0,    0, 0, 0, 1, 0, 0, 0},
         '{0, 1,    0, 0, 0, 1, 0, 0, 0},
         '{0, 3299, 0, 0, 0, 1, 0, 0, 0},
         '{0, 8191, 0, 0, 0, 1, 0, 0, 0},
         '{0, 2,    0, 0, 0, 1, 77503000, 1, 0},
         '{0, 3298, 0, 0, 0, 1, 28, 1, 0},
         '{1, 8191, 0,  0,          -18000, 0, 0, 0, 0},
         '{1, 0,    1,  100,        -15000, 0, 0, 0, 0},
         '{1, 0,    2,  100,        12000,  0, 0, 0, 0},
         '{1, 0,    3,  1000,       -9000,  0, 0, 0, 0},
         '{1, 0,    4,  5000,       -6001,  0, 0, 0, 0},
         '{1, 0,    5,  20000,      -3000,  0, 0, 0, 0},
         '{1, 0,    6,  50000,      0,      0, 0, 0, 0},
         '{1, 0,    7,  100000,     1500,   0, 0, 0, 0},
         '{1, 0,    8,  200000,     3001,   0, 0, 0, 0},
         '{1, 0,    9,  500000,     -7777,  0, 0, 0, 0},
         '{1, 0,    10, 1000000,    9000,   0, 0, 0, 0},
         '{1, 0,    11, 10000000,   10000,  0, 0, 0, 0},
         '{1, 0,    12, 100000000,  12345,  0, 0, 0, 0},
         '{1, 0,    13, 1000000000, 15000,  0, 0, 0, 0},
         '{1, 0,    14, 3000000000, 16999,  0, 0, 0, 0},
         '{1, 0,    15, 64'hFFFF_FFFF, 18000, 0, 0, 0, 0}
      };

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         typed_rd.res   = RW'(dir_rows[i].e_res);
         typed_rd.valid = dir_rows[i].e_valid;
         typed_rd.ang   = AGW'(dir_rows[i].e_ang);
         send_item(dir_rows[i].mode, dir_rows[i].volt, dir_rows[i].idx,
                   dir_rows[i].res, dir_rows[i].ang, dir_rows[i].typed, typed_rd);
      end

      // every phase starts from idle and rewrites all four CSRs
      for (int ph = 0; ph < NPHASES; ph++) begin
         drain_to_idle();
         case (ph)
            0: begin vref = 8191; fixed = 1048575; high = 0; size = 16; end
            1: begin vref = 2;    fixed = 1;       high = 1; size = 31; end
            2: begin vref = 3300; fixed = 1;       high = 0; size = 16; end
            3: begin vref = 8191; fixed = 1048575; high = 1; size = 0;  end
            default: begin
               vref  = ($urandom_range(0, 4) == 0) ? $urandom_range(2, 20)
                                                   : $urandom_range(100, 8191);
               fixed = $urandom_range(1, 1048575);
               high  = $urandom_range(0, 1);
               size  = $urandom_range(0, 31);
            end
         endcase
         csr_write(CSR_VREF, vref);
         csr_write(CSR_FIXED, fixed);
         csr_write(CSR_HIGH_SIDE, high);
         csr_write(CSR_TABLE_SIZE, size);
         csr_valid <= 1'b0;
         n_phase++;
         no_idle = (ph % 4 == 2);
         if (ph >= 2 && $urandom_range(0, 2) != 0) reload_table();
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            typed_rd = '{default: '0};
            if ($urandom_range(0, 9) == 0)
               // stray point load into an arbitrary slot
               send_item(1'b1, $urandom_range(0, 8191), $urandom_range(0, 15),
                         {$urandom}, rand_angle(), 1'b0, typed_rd);
            else
               send_item(1'b0, rand_voltage(), $urandom_range(0, 15),
                         {$urandom}, rand_angle(), 1'b0, typed_rd);
         end
      end

      drain_to_idle();
      $display("covered %0d conversions (%0d at a rail) and %0d point loads",
               n_conv, n_rail, n_load);
      $display("over %0d CSR settings plus the reset setting; %0d mismatches",
               n_phase, mismatches);
      if (mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
